### sv/qes_pkg.sv
// ----------------------------------------------------------------------------
// qes_pkg: shared types and constants for the quad edge setup unit
// Transfer payload structs, the status struct between the edge math and the
// polygon tracker, and the fixed constants of the edge setup.
// ----------------------------------------------------------------------------
package qes_pkg;

  // Default number of edges that make up one polygon.
  localparam int EdgesPerPoly = 4;

  // Running minimum value loaded at the start of every polygon.
  localparam logic signed [15:0] MinInit = 16'sh7FFF;

  // X step values for rising and falling x along the edge.
  localparam logic signed [7:0] StepPos = 8'sd64;
  localparam logic signed [7:0] StepNeg = -8'sd64;

  // Bias added to |dx| for the initial error term.
  localparam logic [16:0] ErrBias = 17'd32;

  // Scale shift applied to rows and |dx|, and the y grid granularity in bits.
  localparam int ScaleShift = 7;
  localparam int GridBits   = 6;

  // One input transfer: an edge given by two vertices and the edge count.
  typedef struct packed {
    logic signed [15:0] first_x;
    logic signed [15:0] first_y;
    logic signed [15:0] second_x;
    logic signed [15:0] second_y;
    logic        [15:0] count_in;
  } in_t;

  // One output transfer: the edge record.
  typedef struct packed {
    logic               edge_live;
    logic signed [15:0] start_x;
    logic signed [15:0] top_y;
    logic        [15:0] rows;
    logic        [22:0] rows_scaled;
    logic signed [7:0]  x_step;
    logic        [22:0] dx_scaled;
    logic        [16:0] error_init;
    logic        [15:0] live_count;
    logic signed [15:0] min_top;
    logic               last_edge;
  } res_t;

  // Edge status handed from the edge math to the polygon tracker.
  typedef struct packed {
    logic               dead;
    logic signed [15:0] top;
    logic        [15:0] count_in;
  } edge_info_t;

  // Polygon status handed from the tracker back to the result assembly.
  typedef struct packed {
    logic        [15:0] live_count;
    logic signed [15:0] min_top;
    logic               last_edge;
  } poly_info_t;

  // Floors a y value to the grid by clearing its low bits.
  function automatic logic signed [15:0] floor_grid(input logic signed [15:0] y);
    floor_grid = {y[15:GridBits], {GridBits{1'b0}}};
  endfunction

endpackage

### sv/quad_edge_setup_unit.sv
// ----------------------------------------------------------------------------
// quad_edge_setup_unit: scanline rasterizer edge setup
// Turns polygon edges into edge records with a per-polygon running minimum.
// ----------------------------------------------------------------------------
// The unit takes one edge per clock while the output is not stalled and
// returns one record per edge, in order, from the result register.
// Each edge passes an input register, one short stage of adds and compares
// and a result register; the polygon state (edge slot, live count, minimum
// top y) updates in the same cycle the record is loaded, so a sustained rate
// of one edge per cycle holds without stalls. A stall on the output backs up
// through both registers; the input accepts while either register has room.
module quad_edge_setup_unit #(
  parameter int EDGES_PER_POLY = qes_pkg::EdgesPerPoly
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qes_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qes_pkg::res_t  out_data_o
);

  logic                 s1_valid_q;
  qes_pkg::in_t         s1_data_q;
  logic                 s2_valid_q;
  qes_pkg::res_t        s2_data_q, s2_data_d;
  logic                 s2_load;
  logic                 s1_load;
  qes_pkg::res_t        geom;
  qes_pkg::edge_info_t  edge_info;
  qes_pkg::poly_info_t  poly_info;

  // Flow control between the two register stages.
  assign s2_load    = s1_valid_q && (!s2_valid_q || !out_stall_i);
  assign s1_load    = in_valid_i && !in_stall_o;
  assign in_stall_o = s1_valid_q && !s2_load;

  // Edge geometry and polygon state.
  qes_edge_calc u_calc (
    .edge_i (s1_data_q),
    .geom_o (geom),
    .info_o (edge_info)
  );

  qes_poly_track #(
    .EDGES_PER_POLY (EDGES_PER_POLY)
  ) u_track (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (s2_load),
    .info_i    (edge_info),
    .poly_o    (poly_info)
  );

  // Result assembly.
  always_comb begin
    s2_data_d            = geom;
    s2_data_d.live_count = poly_info.live_count;
    s2_data_d.min_top    = poly_info.min_top;
    s2_data_d.last_edge  = poly_info.last_edge;
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= 1'b1;
      end else if (s2_load) begin
        s1_valid_q <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_data_q <= in_data_i;
    end
    if (s2_load) begin
      s2_data_q <= s2_data_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_data_o  = s2_data_q;

  // The input only stalls while the input register holds an edge.
  a_stall_needs_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // A horizontal edge carries zero geometry.
  a_dead_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.edge_live) |->
      (out_data_o.rows == 16'd0 && out_data_o.x_step == 8'sd0 &&
       out_data_o.error_init == 17'd0))
    else $error("dead edge with nonzero geometry");

  // A live edge has height and never lies above the running minimum.
  a_live_min : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.edge_live) |->
      (out_data_o.rows != 16'd0 && out_data_o.min_top <= out_data_o.top_y))
    else $error("live edge inconsistent with running minimum");

endmodule

### sv/qes_edge_calc.sv
// ----------------------------------------------------------------------------
// qes_edge_calc: per-edge geometry
// Picks the upper vertex, floors its y to the grid and derives height, step,
// scaled terms and initial error. Horizontal edges give zero geometry.
// ----------------------------------------------------------------------------
module qes_edge_calc (
  input  qes_pkg::in_t       edge_i,
  output qes_pkg::res_t      geom_o,
  output qes_pkg::edge_info_t info_o
);

  logic               dead;
  logic               first_upper;
  logic signed [15:0] ux, uy, lx, ly;
  logic signed [15:0] top;
  logic signed [16:0] rows_w;
  logic signed [16:0] dx_w;
  logic        [16:0] adx;
  logic signed [7:0]  step;

  // Vertex ordering: the vertex with the smaller y is the upper one.
  always_comb begin
    dead        = (edge_i.first_y == edge_i.second_y);
    first_upper = (edge_i.first_y < edge_i.second_y);
    if (first_upper) begin
      ux = edge_i.first_x;
      uy = edge_i.first_y;
      lx = edge_i.second_x;
      ly = edge_i.second_y;
    end else begin
      ux = edge_i.second_x;
      uy = edge_i.second_y;
      lx = edge_i.first_x;
      ly = edge_i.first_y;
    end
  end

  // Height, horizontal run and its magnitude and sign.
  always_comb begin
    top    = qes_pkg::floor_grid(uy);
    rows_w = {ly[15], ly} - {top[15], top};
    dx_w   = {lx[15], lx} - {ux[15], ux};
    adx    = dx_w[16] ? 17'(-dx_w) : 17'(dx_w);
    if (dx_w[16]) begin
      step = qes_pkg::StepNeg;
    end else if (dx_w != 17'sd0) begin
      step = qes_pkg::StepPos;
    end else begin
      step = 8'sd0;
    end
  end

  // Geometry fields; a horizontal edge leaves them all zero.
  always_comb begin
    geom_o = '0;
    if (!dead) begin
      geom_o.edge_live   = 1'b1;
      geom_o.start_x     = ux;
      geom_o.top_y       = top;
      geom_o.rows        = rows_w[15:0];
      geom_o.rows_scaled = {rows_w[15:0], {qes_pkg::ScaleShift{1'b0}}};
      geom_o.x_step      = step;
      geom_o.dx_scaled   = {adx[15:0], {qes_pkg::ScaleShift{1'b0}}};
      geom_o.error_init  = adx + qes_pkg::ErrBias;
    end
    info_o.dead     = dead;
    info_o.top      = top;
    info_o.count_in = edge_i.count_in;
  end

endmodule

### sv/qes_poly_track.sv
// ----------------------------------------------------------------------------
// qes_poly_track: per-polygon state
// Tracks the edge slot within the polygon, the live edge count and the
// running minimum top y. State moves once per edge that enters the result.
// ----------------------------------------------------------------------------
module qes_poly_track #(
  parameter int EDGES_PER_POLY = qes_pkg::EdgesPerPoly
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  qes_pkg::edge_info_t   info_i,
  output qes_pkg::poly_info_t   poly_o
);

  localparam int              SlotW    = $clog2(EDGES_PER_POLY);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(EDGES_PER_POLY - 1);

  logic [SlotW-1:0]   slot_q, slot_d;
  logic signed [15:0] min_q, min_d;
  logic [15:0]        count_q, count_d;
  logic signed [15:0] base_min;
  logic [15:0]        base_count;
  logic               last;

  // Values for this edge, with the polygon start loading fresh state.
  always_comb begin
    base_min   = (slot_q == '0) ? qes_pkg::MinInit : min_q;
    base_count = (slot_q == '0) ? info_i.count_in : count_q;
    last       = (slot_q >= LastSlot);
    count_d    = info_i.dead ? base_count - 16'd1 : base_count;
    min_d      = (!info_i.dead && (info_i.top < base_min)) ? info_i.top : base_min;
    slot_d     = last ? '0 : slot_q + SlotW'(1);

    poly_o.live_count = count_d;
    poly_o.min_top    = qes_pkg::floor_grid(min_d);
    poly_o.last_edge  = last;
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      min_q   <= qes_pkg::MinInit;
      count_q <= '0;
    end else if (advance_i) begin
      slot_q  <= slot_d;
      min_q   <= min_d;
      count_q <= count_d;
    end
  end

endmodule
